[hw/rtl/bmm_pkg.sv]
// Package for the bipartite matching block: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package bmm_pkg;

	localparam int MAX_LEFT_DEF  = 64;
	localparam int MAX_RIGHT_DEF = 64;
	localparam int VTX_W         = 6;
	localparam int CNT_W         = 7;
	localparam int MATCH_W       = 6;
	localparam logic [CNT_W-1:0] LEFT_COUNT_RST = 7'd64;
	localparam logic [MATCH_W-1:0] MATCH_SAT    = 6'd63;

	localparam logic REQ_EDGE    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EDGE,
		ST_ROOT,
		ST_RDROW,
		ST_SCAN,
		ST_PART,
		ST_COMMIT,
		ST_NEXT,
		ST_CLEAR,
		ST_REPORT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic edge_wr;
		logic start_run;
		logic root_init;
		logic row_rd;
		logic scan;
		logic part_chk;
		logic commit_step;
		logic next_root;
		logic clear_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic roots_done;
		logic scan_fail;
		logic scan_free;
		logic stack_empty;
		logic commit_done;
		logic clear_done;
	} sts_t;

endpackage

[hw/rtl/bmm_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module bmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/bmm_ctrl.sv]
// Controller state machine of the bipartite matching block.
// Depends on bmm_pkg.
module bmm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          req_type,
	input  bmm_pkg::sts_t sts,
	output logic          busy,
	output logic          done,
	output bmm_pkg::cmd_t cmd
);
	import bmm_pkg::*;

	state_t state_q, state_nxt;

	// Hold state; clear the RAMs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.clear_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && req_type == REQ_COMPUTE) state_nxt = ST_ROOT;
				else if (start) state_nxt = ST_EDGE;
			end
			ST_EDGE: state_nxt = ST_IDLE;
			ST_ROOT: begin
				if (sts.roots_done) state_nxt = ST_CLEAR;
				else                state_nxt = ST_RDROW;
			end
			ST_RDROW: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (!sts.scan_fail) state_nxt = ST_PART;
				else if (sts.stack_empty) state_nxt = ST_NEXT;
				else state_nxt = ST_RDROW;
			end
			ST_PART: begin
				if (sts.scan_free) state_nxt = ST_COMMIT;
				else               state_nxt = ST_RDROW;
			end
			ST_COMMIT: begin
				if (sts.commit_done) state_nxt = ST_NEXT;
			end
			ST_NEXT: state_nxt = ST_ROOT;
			ST_CLEAR: begin
				if (sts.clear_done) state_nxt = ST_REPORT;
			end
			ST_REPORT: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		done = 1'b0;
		case (state_q)
			ST_INIT:   cmd.clear_step = 1'b1;
			ST_IDLE: begin
				cmd.edge_wr   = start && req_type == REQ_EDGE;
				cmd.start_run = start && req_type == REQ_COMPUTE;
			end
			ST_ROOT:   cmd.root_init   = !sts.roots_done;
			ST_RDROW:  cmd.row_rd      = 1'b1;
			ST_SCAN:   cmd.scan        = 1'b1;
			ST_PART:   cmd.part_chk    = 1'b1;
			ST_COMMIT: cmd.commit_step = 1'b1;
			ST_NEXT:   cmd.next_root   = 1'b1;
			ST_CLEAR:  cmd.clear_step  = 1'b1;
			ST_REPORT: done            = 1'b1;
			default:   cmd             = '0;
		endcase
	end

	// Report only after the clearing sweep
	a_done_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_CLEAR)
		else $error("report without clear");
	a_no_edge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.edge_wr)
		else $error("edge write while busy");
	a_busy_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_run |=> busy)
		else $error("compute not started");
endmodule

[hw/rtl/bmm_dp.sv]
// Datapath: adjacency RAM, partner RAM, visit marks, search stack, count.
// Depends on bmm_pkg and bmm_ram.
module bmm_dp #(
	parameter int MAX_LEFT  = bmm_pkg::MAX_LEFT_DEF,
	parameter int MAX_RIGHT = bmm_pkg::MAX_RIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmm_pkg::cmd_t               cmd,
	input  logic [bmm_pkg::VTX_W-1:0]   left_vertex,
	input  logic [bmm_pkg::VTX_W-1:0]   right_vertex,
	input  logic [bmm_pkg::CNT_W-1:0]   left_count,
	output bmm_pkg::sts_t               sts,
	output logic [bmm_pkg::MATCH_W-1:0] match_count
);
	import bmm_pkg::*;

	localparam int LW = $clog2(MAX_LEFT);
	localparam int RW = $clog2(MAX_RIGHT);
	localparam int SW = $clog2(MAX_RIGHT + 2);
	localparam int FW = LW + RW;
	localparam int CW = (LW > CNT_W ? LW : CNT_W) + 1;
	localparam int NC = (MAX_LEFT > MAX_RIGHT) ? MAX_LEFT : MAX_RIGHT;
	localparam int KW = $clog2(NC);

	// Adjacency RAM, one row per left vertex
	logic                 adj_we;
	logic [LW-1:0]        adj_waddr, adj_raddr;
	logic [MAX_RIGHT-1:0] adj_wdata, adj_row;

	// Stack RAM, frames {left, chosen right}
	logic          stk_we;
	logic [RW-1:0] stk_waddr, stk_raddr;
	logic [FW-1:0] stk_wdata, stk_rdata;

	// Partner RAM, left vertex per right vertex, 0 when unmatched
	logic          part_we;
	logic [RW-1:0] part_waddr, part_raddr;
	logic [LW-1:0] part_wdata, part_rdata;

	logic [MAX_RIGHT-1:0] visited_q;
	logic [LW:0]          root_q;
	logic [LW-1:0]        cur_q;
	logic [SW-1:0]        depth_q;
	logic [RW-1:0]        chosen_q;
	logic [MATCH_W-1:0]   total_q;
	logic [KW-1:0]        clr_q;
	logic [RW-1:0]        pos_q;     // commit walk index
	logic                 cmt_rd_q;
	logic                 hit_q;     // current root found a free vertex

	// Edge accepted only in range; stored bits are OR-ed in by read-modify-write
	logic edge_ok;
	assign edge_ok = (left_vertex != '0) && (right_vertex != '0)
		&& (int'(left_vertex) < MAX_LEFT)
		&& (int'(right_vertex) < MAX_RIGHT);

	// Edge pipeline: read row, then write row with bit set
	logic          ewr_s1;
	logic [LW-1:0] el_s1;
	logic [RW-1:0] er_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ewr_s1 <= 1'b0;
		end else begin
			ewr_s1 <= cmd.edge_wr && edge_ok;
		end
	end
	always_ff @(posedge clk) begin
		el_s1 <= LW'(left_vertex);
		er_s1 <= RW'(right_vertex);
	end

	// Search scan: first unvisited neighbor in the row of cur_q
	logic [MAX_RIGHT-1:0] cand;
	logic                 found;
	logic [RW-1:0]        pick;
	assign cand = adj_row & ~visited_q & ~{{(MAX_RIGHT-1){1'b0}}, 1'b1};
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = MAX_RIGHT - 1; i >= 1; i--) begin
			if (cand[i]) begin
				found = 1'b1;
				pick  = RW'(i);
			end
		end
	end

	logic [CW-1:0] lim;
	assign lim = (CW'(left_count) > CW'(MAX_LEFT)) ? CW'(MAX_LEFT) : CW'(left_count);

	// Clearing sweep covers both RAMs
	logic clr_left, clr_right;
	assign clr_left  = int'(clr_q) < MAX_LEFT;
	assign clr_right = int'(clr_q) < MAX_RIGHT;

	assign sts.roots_done  = CW'(root_q) >= lim;
	assign sts.scan_free   = part_rdata == '0;
	assign sts.scan_fail   = !found;
	assign sts.stack_empty = depth_q <= SW'(1);
	assign sts.commit_done = (depth_q <= SW'(1)) || (cmt_rd_q && pos_q == '0);
	assign sts.clear_done  = clr_q == KW'(NC - 1);

	// Adjacency RAM port control
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = el_s1;
		adj_wdata = adj_row | (MAX_RIGHT'(1) << er_s1);
		adj_raddr = cmd.row_rd ? cur_q : LW'(left_vertex);
		if (ewr_s1) begin
			adj_we = 1'b1;
		end else if (cmd.clear_step && clr_left) begin
			adj_we    = 1'b1;
			adj_waddr = LW'(clr_q);
			adj_wdata = '0;
		end
	end

	// Stack RAM port control: push frame when the pick is matched
	always_comb begin
		stk_we    = cmd.part_chk && !sts.scan_free;
		stk_waddr = RW'(depth_q - SW'(1));
		stk_wdata = {cur_q, chosen_q};
		stk_raddr = cmd.row_rd ? RW'(depth_q - SW'(2)) : pos_q;
	end

	// Partner RAM port control: look up the pick, write on a free pick, commit and clear
	always_comb begin
		part_raddr = pick;
		part_we    = 1'b0;
		part_waddr = chosen_q;
		part_wdata = cur_q;
		if (cmd.part_chk && sts.scan_free) begin
			part_we = 1'b1;
		end else if (cmd.commit_step && depth_q > SW'(1) && cmt_rd_q) begin
			part_we    = 1'b1;
			part_waddr = stk_rdata[RW-1:0];
			part_wdata = stk_rdata[FW-1:RW];
		end else if (cmd.clear_step && clr_right) begin
			part_we    = 1'b1;
			part_waddr = RW'(clr_q);
			part_wdata = '0;
		end
	end

	bmm_ram #(.WIDTH(MAX_RIGHT), .DEPTH(MAX_LEFT)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_row));
	bmm_ram #(.WIDTH(FW), .DEPTH(MAX_RIGHT)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata));
	bmm_ram #(.WIDTH(LW), .DEPTH(MAX_RIGHT)) u_part (
		.clk(clk), .we(part_we), .waddr(part_waddr), .wdata(part_wdata),
		.raddr(part_raddr), .rdata(part_rdata));

	// Search control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			root_q    <= '0;
			cur_q     <= '0;
			depth_q   <= '0;
			chosen_q  <= '0;
			total_q   <= '0;
			clr_q     <= '0;
			pos_q     <= '0;
			cmt_rd_q  <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.start_run) begin
				root_q  <= (LW+1)'(1);
				total_q <= '0;
				clr_q   <= '0;
			end
			// Start a search from the root
			if (cmd.root_init) begin
				visited_q <= '0;
				cur_q     <= root_q[LW-1:0];
				depth_q   <= SW'(1);
				hit_q     <= 1'b0;
			end
			if (cmd.scan) begin
				if (found) begin
					visited_q[pick] <= 1'b1;
					chosen_q        <= pick;
				end else begin
					// Dead end: pop, resume the parent frame
					depth_q <= depth_q - SW'(1);
					if (depth_q > SW'(1)) cur_q <= stk_rdata[FW-1:RW];
				end
			end
			if (cmd.part_chk) begin
				if (sts.scan_free) begin
					// Free vertex: walk stack from the top down
					hit_q    <= 1'b1;
					pos_q    <= RW'(depth_q - SW'(2));
					cmt_rd_q <= 1'b0;
				end else begin
					cur_q   <= part_rdata;
					depth_q <= depth_q + SW'(1);
				end
			end
			// Commit: each lower frame takes its chosen right vertex
			if (cmd.commit_step && depth_q > SW'(1)) begin
				if (!cmt_rd_q) begin
					cmt_rd_q <= 1'b1;
				end else if (pos_q != '0) begin
					pos_q    <= pos_q - RW'(1);
					cmt_rd_q <= 1'b0;
				end
			end
			if (cmd.next_root) begin
				root_q <= root_q + (LW+1)'(1);
				if (hit_q && total_q != MATCH_SAT)
					total_q <= total_q + MATCH_W'(1);
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + KW'(1);
			end
		end
	end

	assign match_count = total_q;
endmodule

[hw/rtl/bipartite_max_matching_top.sv]
// Top level of the bipartite matching block: controller, datapath, config.
// Depends on bmm_pkg, bmm_ctrl, bmm_dp, bmm_ram.
//
//  channel  | signals                                    | handshake
//  request  | start, req_type, left_vertex, right_vertex | start & !busy
//  result   | done, match_count                          | done, one cycle
//  config   | cfg_we, cfg_data (left_count)              | cfg_we
//
// An edge request keeps busy high while its row is rewritten. A compute
// request, for each root, starts a search, repeats a row read and a scan,
// checks the partner of each neighbor found, walks the stacked frames to
// commit and advances to the next root; it then clears
// max(MAX_LEFT, MAX_RIGHT) rows and reports in the next cycle. After reset
// the same clearing pass runs with busy high. Reset is asynchronous and sets
// left_count to 64; the result cannot be stalled.
module bipartite_max_matching_top #(
	parameter int MAX_LEFT  = bmm_pkg::MAX_LEFT_DEF,
	parameter int MAX_RIGHT = bmm_pkg::MAX_RIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [bmm_pkg::VTX_W-1:0]   left_vertex,
	input  logic [bmm_pkg::VTX_W-1:0]   right_vertex,
	input  logic                        cfg_we,
	input  logic [bmm_pkg::CNT_W-1:0]   cfg_data,
	output logic                        done,
	output logic [bmm_pkg::MATCH_W-1:0] match_count
);
	import bmm_pkg::*;

	logic [CNT_W-1:0] left_count_q;
	cmd_t cmd;
	sts_t sts;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q <= LEFT_COUNT_RST;
		end else if (cfg_we) begin
			left_count_q <= cfg_data;
		end
	end

	bmm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.sts(sts), .busy(busy), .done(done), .cmd(cmd));

	bmm_dp #(.MAX_LEFT(MAX_LEFT), .MAX_RIGHT(MAX_RIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .left_vertex(left_vertex),
		.right_vertex(right_vertex), .left_count(left_count_q), .sts(sts),
		.match_count(match_count));
endmodule
